@@ rtl/fjop_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and defaults for the flat json object parser
package fjop_pkg;

  localparam int DEF_MAX_KEYS    = 16;
  localparam int DEF_KEY_BYTES   = 32;
  localparam int DEF_VALUE_BYTES = 64;

  // bytes dropped after a backslash-u escape
  localparam logic [2:0] USKIP_LEN = 3'd4;

  // result queue depth, room for two results per accepted byte
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  typedef enum logic [3:0] {
    P_WAIT       = 4'd0,
    P_EXPECT_KEY = 4'd1,
    P_KEY        = 4'd2,
    P_KEY_ESC    = 4'd3,
    P_KEY_SKIP   = 4'd4,
    P_AFTER_KEY  = 4'd5,
    P_BEFORE_VAL = 4'd6,
    P_VAL        = 4'd7,
    P_VAL_ESC    = 4'd8,
    P_VAL_SKIP   = 4'd9,
    P_TOKEN      = 4'd10,
    P_AFTER_VAL  = 4'd11,
    P_DONE       = 4'd12
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] entry;
    logic [5:0] offset;
    logic [7:0] ch;
    logic       failed;
    logic       run_end;
  } res_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      data;
  } push_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

@@ rtl/fjop_in_if.sv @@
`timescale 1ns / 1ps
// byte stream channel into the parser
interface fjop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ rtl/fjop_out_if.sv @@
`timescale 1ns / 1ps
// result channel out of the parser
interface fjop_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] entry;
  logic [5:0] offset;
  logic [7:0] ch;
  logic       failed;
  logic       run_end;

  modport source (output valid, output kind, output entry, output offset, output ch,
                  output failed, output run_end, input ready);
  modport sink   (input valid, input kind, input entry, input offset, input ch,
                  input failed, input run_end, output ready);
endinterface

@@ rtl/fjop_res_queue.sv @@
`timescale 1ns / 1ps
// small result queue: up to two pushes and one pop per cycle
module fjop_res_queue
  import fjop_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output res_t  head,
  output logic  not_empty,
  output logic  room_two
);

  res_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic [Q_PTR_W-1:0]  wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + Q_PTR_W'(1);
  assign head       = mem[rd_ptr];
  assign not_empty  = (count != '0);
  assign room_two   = (32'(count) + 2) <= Q_DEPTH;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.data[0];
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_inc] <= push.data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
    end
  end

endmodule

@@ rtl/flat_json_object_parser_top.sv @@
`timescale 1ns / 1ps
// Flat JSON object parser: takes one message byte per transaction and emits key and
// value character writes (entry, offset, byte; zero terminates a string) plus a final
// status result. Each accepted byte is decoded combinationally from the parser
// phase registers and yields zero, one or two results, which go into a four-entry
// result queue; the result port drains that queue at one transaction per cycle while
// the receiver is ready. The input is ready whenever the queue has room for two
// results, so a byte can be taken every cycle as long as results are drained at
// least as fast as they are produced; a byte's results are registered in the queue.
module flat_json_object_parser_top
  import fjop_pkg::*;
#(
  parameter int MAX_KEYS    = DEF_MAX_KEYS,
  parameter int KEY_BYTES   = DEF_KEY_BYTES,
  parameter int VALUE_BYTES = DEF_VALUE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  fjop_in_if.sink           msg,
  fjop_out_if.source        res
);

  localparam int CAP_MAX = (KEY_BYTES > VALUE_BYTES) ? KEY_BYTES : VALUE_BYTES;
  localparam int OFS_W   = $clog2(CAP_MAX);
  localparam int EC_W    = $clog2(MAX_KEYS + 1);

  phase_t           phase;
  phase_t           phase_next;
  logic [EC_W-1:0]  entry_count;
  logic [EC_W-1:0]  entry_count_next;
  logic [OFS_W-1:0] char_offset;
  logic [OFS_W-1:0] char_offset_next;
  logic [2:0]       escape_skip_left;
  logic [2:0]       escape_skip_left_next;

  logic             accept;
  logic             room_two;
  logic             not_empty;
  res_t             head;
  push_t            push;

  logic [1:0]       nres;
  res_t [1:0]       slot;
  logic             fin;
  logic             do_after;
  logic [1:0]       kind_s;
  logic [31:0]      cap_s;
  logic [7:0]       ch_s;
  logic [7:0]       b;

  function automatic res_t mk(logic [1:0] k, logic [31:0] e, logic [31:0] o,
                              logic [7:0] c, logic f);
    res_t r;
    r.kind    = k;
    r.entry   = e[4:0];
    r.offset  = o[5:0];
    r.ch      = c;
    r.failed  = f;
    r.run_end = 1'b0;
    return r;
  endfunction

  assign accept    = msg.valid && msg.ready;
  assign msg.ready = room_two;
  assign b         = msg.data_byte;

  // per-byte decode
  always_comb begin
    phase_next            = phase;
    entry_count_next      = entry_count;
    char_offset_next      = char_offset;
    escape_skip_left_next = escape_skip_left;
    nres                  = 2'd0;
    slot                  = '0;
    fin                   = 1'b0;
    do_after              = 1'b0;
    kind_s                = KIND_KEY;
    cap_s                 = 32'(KEY_BYTES);
    ch_s                  = b;

    if (phase == P_DONE) begin
      if (msg.end_of_message) begin
        phase_next            = P_WAIT;
        entry_count_next      = '0;
        char_offset_next      = '0;
        escape_skip_left_next = '0;
      end
    end else begin
      if (phase == P_VAL || phase == P_VAL_ESC || phase == P_VAL_SKIP ||
          phase == P_BEFORE_VAL || phase == P_TOKEN) begin
        kind_s = KIND_VAL;
        cap_s  = 32'(VALUE_BYTES);
      end

      unique case (phase)
        P_WAIT: begin
          if (b == CH_LBRACE) begin
            phase_next = P_EXPECT_KEY;
          end else if (!is_ws(b)) begin
            slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
            nres = nres + 2'd1;
            phase_next = P_DONE;
            fin = 1'b1;
          end
        end
        P_EXPECT_KEY: begin
          if (is_ws(b)) begin
            phase_next = phase;
          end else if (b == CH_RBRACE) begin
            slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b0);
            nres = nres + 2'd1;
            phase_next = P_DONE;
            fin = 1'b1;
          end else if (b == CH_QUOTE && 32'(entry_count) < 32'(MAX_KEYS)) begin
            char_offset_next = '0;
            phase_next = P_KEY;
          end else begin
            slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
            nres = nres + 2'd1;
            phase_next = P_DONE;
            fin = 1'b1;
          end
        end
        P_KEY, P_VAL: begin
          if (b == CH_QUOTE) begin
            slot[nres[0]] = mk(kind_s, 32'(entry_count_next), 32'(char_offset_next),
                               8'd0, 1'b0);
            nres = nres + 2'd1;
            char_offset_next = '0;
            if (kind_s == KIND_VAL) begin
              entry_count_next = entry_count_next + EC_W'(1);
              phase_next = P_AFTER_VAL;
            end else begin
              phase_next = P_AFTER_KEY;
            end
          end else if (b == CH_BSLASH) begin
            phase_next = (kind_s == KIND_VAL) ? P_VAL_ESC : P_KEY_ESC;
          end else if ((32'(char_offset_next) + 32'd1) < cap_s) begin
            slot[nres[0]] = mk(kind_s, 32'(entry_count_next), 32'(char_offset_next),
                               b, 1'b0);
            nres = nres + 2'd1;
            char_offset_next = char_offset_next + OFS_W'(1);
          end
        end
        P_KEY_ESC, P_VAL_ESC: begin
          if (b == CH_LOW_U) begin
            escape_skip_left_next = USKIP_LEN;
            phase_next = (kind_s == KIND_VAL) ? P_VAL_SKIP : P_KEY_SKIP;
          end else begin
            if (b == CH_LOW_N) begin
              ch_s = CH_LF;
            end else if (b == CH_LOW_T) begin
              ch_s = CH_TAB;
            end else if (b == CH_LOW_R) begin
              ch_s = CH_CR;
            end
            if ((32'(char_offset_next) + 32'd1) < cap_s) begin
              slot[nres[0]] = mk(kind_s, 32'(entry_count_next), 32'(char_offset_next),
                                 ch_s, 1'b0);
              nres = nres + 2'd1;
              char_offset_next = char_offset_next + OFS_W'(1);
            end
            phase_next = (kind_s == KIND_VAL) ? P_VAL : P_KEY;
          end
        end
        P_KEY_SKIP, P_VAL_SKIP: begin
          if (escape_skip_left != 3'd0) begin
            escape_skip_left_next = escape_skip_left - 3'd1;
          end
          if (escape_skip_left_next == 3'd0) begin
            phase_next = (kind_s == KIND_VAL) ? P_VAL : P_KEY;
          end
        end
        P_AFTER_KEY: begin
          if (b == CH_COLON) begin
            phase_next = P_BEFORE_VAL;
          end else if (!is_ws(b)) begin
            slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
            nres = nres + 2'd1;
            phase_next = P_DONE;
            fin = 1'b1;
          end
        end
        P_BEFORE_VAL, P_TOKEN: begin
          if (phase == P_BEFORE_VAL && is_ws(b)) begin
            phase_next = phase;
          end else if (phase == P_BEFORE_VAL && b == CH_QUOTE) begin
            char_offset_next = '0;
            phase_next = P_VAL;
          end else if (b == CH_COMMA || b == CH_RBRACE ||
                       (phase == P_TOKEN && is_ws(b))) begin
            // empty bare value right after the colon terminates at offset zero
            if (phase == P_BEFORE_VAL) begin
              char_offset_next = '0;
            end
            slot[nres[0]] = mk(KIND_VAL, 32'(entry_count_next), 32'(char_offset_next),
                               8'd0, 1'b0);
            nres = nres + 2'd1;
            char_offset_next = '0;
            entry_count_next = entry_count_next + EC_W'(1);
            do_after = 1'b1;
          end else begin
            if (phase == P_BEFORE_VAL) begin
              char_offset_next = '0;
            end
            if ((32'(char_offset_next) + 32'd1) < cap_s) begin
              slot[nres[0]] = mk(KIND_VAL, 32'(entry_count_next), 32'(char_offset_next),
                                 b, 1'b0);
              nres = nres + 2'd1;
              char_offset_next = char_offset_next + OFS_W'(1);
            end
            phase_next = P_TOKEN;
          end
        end
        P_AFTER_VAL: begin
          do_after = 1'b1;
        end
        default: begin
          slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
          nres = nres + 2'd1;
          phase_next = P_DONE;
          fin = 1'b1;
        end
      endcase

      // separator handling after a finished value
      if (do_after) begin
        if (b == CH_COMMA) begin
          phase_next = P_EXPECT_KEY;
        end else if (b == CH_RBRACE) begin
          slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b0);
          nres = nres + 2'd1;
          phase_next = P_DONE;
          fin = 1'b1;
        end else if (is_ws(b)) begin
          phase_next = P_AFTER_VAL;
        end else begin
          slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
          nres = nres + 2'd1;
          phase_next = P_DONE;
          fin = 1'b1;
        end
      end

      // message end: a failure result unless the object closed, then the parser state resets
      if (msg.end_of_message) begin
        if (!fin) begin
          slot[nres[0]] = mk(KIND_DONE, 32'(entry_count_next), 32'd0, 8'd0, 1'b1);
          nres = nres + 2'd1;
        end
        phase_next            = P_WAIT;
        entry_count_next      = '0;
        char_offset_next      = '0;
        escape_skip_left_next = '0;
      end

      if (nres == 2'd1) begin
        slot[0].run_end = 1'b1;
      end else if (nres == 2'd2) begin
        slot[1].run_end = 1'b1;
      end
    end
  end

  always_comb begin
    push.n    = accept ? nres : 2'd0;
    push.data = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= P_WAIT;
      entry_count      <= '0;
      char_offset      <= '0;
      escape_skip_left <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      entry_count      <= entry_count_next;
      char_offset      <= char_offset_next;
      escape_skip_left <= escape_skip_left_next;
    end
  end

  fjop_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (res.valid && res.ready),
    .head      (head),
    .not_empty (not_empty),
    .room_two  (room_two)
  );

  assign res.valid   = not_empty;
  assign res.kind    = head.kind;
  assign res.entry   = head.entry;
  assign res.offset  = head.offset;
  assign res.ch      = head.ch;
  assign res.failed  = head.failed;
  assign res.run_end = head.run_end;

endmodule

@@ test/tb_flat_json_object_parser_top.sv @@
`timescale 1ns / 1ps
// testbench for the flat json object parser: byte messages checked against a behavioral parser
module tb_flat_json_object_parser_top;
  import fjop_pkg::*;

  localparam int RANDOM_BYTES = 350;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fjop_in_if  msg_if ();
  fjop_out_if res_if ();

  flat_json_object_parser_top i_dut (
    .clk(clk),
    .rst(rst),
    .msg(msg_if),
    .res(res_if)
  );

  always #5 clk = ~clk;

  // parser state as the predictor sees it
  phase_t      ph;
  int unsigned n_entries;
  int unsigned pos;
  int unsigned skip_left;
  bit          run_closed;

  res_t        step_out[$];
  res_t        expected_parse_out[$];
  logic [7:0]  frame[$];

  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;

  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned directed_bytes;
  int unsigned char_writes;
  int unsigned runs_ok;
  int unsigned runs_failed;
  int unsigned holds_done;
  int unsigned mismatches;
  int unsigned idle_cycles;
  res_t        got;
  res_t        want;

  // ---------------- behavioral parser ----------------

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic void clear_state();
    ph        = P_WAIT;
    n_entries = 0;
    pos       = 0;
    skip_left = 0;
  endfunction

  function automatic void emit(logic [1:0] k, int unsigned e, int unsigned o, logic [7:0] c,
                               logic f);
    res_t r;
    r.kind    = k;
    r.entry   = 5'(e);
    r.offset  = 6'(o);
    r.ch      = c;
    r.failed  = f;
    r.run_end = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void finish_parse(logic f);
    emit(KIND_DONE, n_entries, 0, 8'h00, f);
    ph         = P_DONE;
    run_closed = 1'b1;
  endfunction

  // characters past capacity are dropped silently
  function automatic void store_char(logic [1:0] k, int unsigned cap, logic [7:0] c);
    if (pos + 1 < cap) begin
      emit(k, n_entries, pos, c, 1'b0);
      pos++;
    end
  endfunction

  function automatic void close_string(logic [1:0] k);
    emit(k, n_entries, pos, 8'h00, 1'b0);
    pos = 0;
    if (k == KIND_VAL) n_entries++;
  endfunction

  function automatic void value_done(logic [7:0] b);
    if (b == CH_COMMA) ph = P_EXPECT_KEY;
    else if (b == CH_RBRACE) finish_parse(1'b0);
    else if (is_blank(b)) ph = P_AFTER_VAL;
    else finish_parse(1'b1);
  endfunction

  function automatic void string_step(logic [7:0] b, logic [1:0] k, int unsigned cap,
                                      phase_t p_in, phase_t p_esc, phase_t p_skip,
                                      phase_t p_next);
    logic [7:0] c;
    if (ph == p_in) begin
      if (b == CH_QUOTE) begin
        close_string(k);
        ph = p_next;
      end else if (b == CH_BSLASH) begin
        ph = p_esc;
      end else begin
        store_char(k, cap, b);
      end
    end else if (ph == p_esc) begin
      if (b == CH_LOW_U) begin
        skip_left = USKIP_LEN;
        ph        = p_skip;
      end else begin
        case (b)
          CH_LOW_N: c = CH_LF;
          CH_LOW_T: c = CH_TAB;
          CH_LOW_R: c = CH_CR;
          default:  c = b;
        endcase
        store_char(k, cap, c);
        ph = p_in;
      end
    end else begin
      if (skip_left > 0) skip_left--;
      if (skip_left == 0) ph = p_in;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eom);
    int unsigned last;
    step_out.delete();
    run_closed = 1'b0;
    // after a finish everything up to the final byte is ignored
    if (ph == P_DONE) begin
      if (eom) clear_state();
      return;
    end
    case (ph)
      P_WAIT: begin
        if (b == CH_LBRACE) ph = P_EXPECT_KEY;
        else if (!is_blank(b)) finish_parse(1'b1);
      end
      P_EXPECT_KEY: begin
        if (!is_blank(b)) begin
          if (b == CH_RBRACE) begin
            finish_parse(1'b0);
          end else if (b == CH_QUOTE) begin
            if (n_entries >= DEF_MAX_KEYS) begin
              finish_parse(1'b1);
            end else begin
              pos = 0;
              ph  = P_KEY;
            end
          end else begin
            finish_parse(1'b1);
          end
        end
      end
      P_KEY, P_KEY_ESC, P_KEY_SKIP:
        string_step(b, KIND_KEY, DEF_KEY_BYTES, P_KEY, P_KEY_ESC, P_KEY_SKIP, P_AFTER_KEY);
      P_AFTER_KEY: begin
        if (b == CH_COLON) ph = P_BEFORE_VAL;
        else if (!is_blank(b)) finish_parse(1'b1);
      end
      P_BEFORE_VAL: begin
        if (!is_blank(b)) begin
          pos = 0;
          if (b == CH_QUOTE) begin
            ph = P_VAL;
          end else if (b == CH_COMMA || b == CH_RBRACE) begin
            // empty bare value still makes an entry
            close_string(KIND_VAL);
            value_done(b);
          end else begin
            store_char(KIND_VAL, DEF_VALUE_BYTES, b);
            ph = P_TOKEN;
          end
        end
      end
      P_VAL, P_VAL_ESC, P_VAL_SKIP:
        string_step(b, KIND_VAL, DEF_VALUE_BYTES, P_VAL, P_VAL_ESC, P_VAL_SKIP, P_AFTER_VAL);
      P_TOKEN: begin
        if (b == CH_COMMA || b == CH_RBRACE || is_blank(b)) begin
          close_string(KIND_VAL);
          value_done(b);
        end else begin
          store_char(KIND_VAL, DEF_VALUE_BYTES, b);
        end
      end
      P_AFTER_VAL: value_done(b);
      default:     finish_parse(1'b1);
    endcase
    if (eom) begin
      if (!run_closed) finish_parse(1'b1);
      clear_state();
    end
    if (step_out.size() > 0) begin
      last = step_out.size() - 1;
      step_out[last].run_end = 1'b1;
    end
    foreach (step_out[i]) expected_parse_out.push_back(step_out[i]);
  endfunction

  // ---------------- result checking ----------------

  function automatic void report_bad(string what, res_t exp_r, res_t got_r);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected kind=%0d entry=%0d offset=%0d ch=%02h failed=%0d end=%0d",
               $realtime, what, exp_r.kind, exp_r.entry, exp_r.offset, exp_r.ch,
               exp_r.failed, exp_r.run_end);
      $display("%0t:   got      kind=%0d entry=%0d offset=%0d ch=%02h failed=%0d end=%0d",
               $realtime, got_r.kind, got_r.entry, got_r.offset, got_r.ch, got_r.failed,
               got_r.run_end);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got.kind    = res_if.kind;
      got.entry   = res_if.entry;
      got.offset  = res_if.offset;
      got.ch      = res_if.ch;
      got.failed  = res_if.failed;
      got.run_end = res_if.run_end;
      if (got.kind == KIND_DONE) begin
        if (got.failed) runs_failed++;
        else runs_ok++;
      end else begin
        char_writes++;
      end
      if (expected_parse_out.size() == 0) begin
        report_bad("result with nothing expected", '0, got);
      end else begin
        want = expected_parse_out.pop_front();
        if (got.kind !== want.kind || got.entry !== want.entry ||
            got.offset !== want.offset || got.ch !== want.ch ||
            got.failed !== want.failed || got.run_end !== want.run_end)
          report_bad("field mismatch", want, got);
      end
    end
  end

  // stops the run when no transaction happens on either side for too long
  always @(posedge clk) begin
    if (rst || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- traffic shaping ----------------

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic int unsigned src_gap();
    int unsigned r;
    if (!src_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned sink_stall();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold while the sender keeps offering bytes
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
        holds_done++;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        stall = sink_stall();
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    gap = src_gap();
    repeat (gap) begin
      @(negedge clk);
      msg_if.valid <= 1'b0;
    end
    @(negedge clk);
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= b;
    msg_if.end_of_message <= eom;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    parse_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int unsigned i = 0; i < frame.size(); i++) send_byte(frame[i], i + 1 == frame.size());
    frame.delete();
    frames_sent++;
  endtask

  // drop valid and wait for every expected result; always returns on a rising edge
  task automatic end_test();
    @(negedge clk);
    msg_if.valid <= 1'b0;
    do @(posedge clk); while (expected_parse_out.size() != 0);
  endtask

  // ---------------- message builders ----------------

  function automatic void add_str(string s);
    foreach (s[i]) frame.push_back(s[i]);
  endfunction

  function automatic void add_ws();
    int unsigned n;
    if ($urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       frame.push_back(CH_SPACE);
        1:       frame.push_back(CH_TAB);
        2:       frame.push_back(CH_LF);
        default: frame.push_back(CH_CR);
      endcase
    end
  endfunction

  // any byte except quote and backslash, mostly printable
  function automatic logic [7:0] plain_char();
    int unsigned r;
    logic [7:0] c;
    r = $urandom_range(0, 19);
    if (r == 0) return rand_byte(8'h80, 8'hFF);
    if (r == 1) return rand_byte(8'h00, 8'h1F);
    c = rand_byte(8'h20, 8'h7E);
    return (c == CH_QUOTE || c == CH_BSLASH) ? 8'h5F : c;
  endfunction

  // bytes that never end a bare token and never open a string
  function automatic logic [7:0] token_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_byte(8'h30, 8'h39);
      4, 5, 6, 7: return rand_byte(8'h61, 8'h7A);
      8:          return ($urandom_range(0, 1) != 0) ? 8'h2D : 8'h2E;
      default:    return rand_byte(8'h80, 8'hFF);
    endcase
  endfunction

  function automatic void add_escape();
    frame.push_back(CH_BSLASH);
    case ($urandom_range(0, 7))
      0: frame.push_back(CH_LOW_N);
      1: frame.push_back(CH_LOW_T);
      2: frame.push_back(CH_LOW_R);
      3: begin
        frame.push_back(CH_LOW_U);
        repeat (USKIP_LEN) frame.push_back(rand_byte(0, 255));
      end
      4: frame.push_back(CH_QUOTE);
      5: frame.push_back(CH_BSLASH);
      default: frame.push_back(rand_byte(0, 255));
    endcase
  endfunction

  // mostly short, now and then around the capacity
  function automatic int unsigned pick_len(int unsigned cap);
    if ($urandom_range(0, 99) < 95) return $urandom_range(0, 6);
    return $urandom_range(cap - 2, cap + 3);
  endfunction

  function automatic void gen_string(int unsigned n);
    frame.push_back(CH_QUOTE);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) add_escape();
      else frame.push_back(plain_char());
    end
    frame.push_back(CH_QUOTE);
  endfunction

  function automatic void gen_value();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      gen_string(pick_len(DEF_VALUE_BYTES));
    end else if (r < 85) begin
      n = pick_len(DEF_VALUE_BYTES);
      if (n == 0) n = 1;
      repeat (n) frame.push_back(token_char());
    end
  endfunction

  function automatic void gen_object(int unsigned members);
    add_ws();
    frame.push_back(CH_LBRACE);
    for (int unsigned i = 0; i < members; i++) begin
      add_ws();
      gen_string(pick_len(DEF_KEY_BYTES));
      add_ws();
      frame.push_back(CH_COLON);
      add_ws();
      gen_value();
      add_ws();
      if (i + 1 < members || $urandom_range(0, 3) == 0) frame.push_back(CH_COMMA);
    end
    add_ws();
    frame.push_back(CH_RBRACE);
  endfunction

  // ---------------- tests ----------------

  task automatic test_escapes_and_trailing_comma();
    // key with a skipped unicode escape, value with every escape kind, then a trailing comma
    add_str("{\"a\\u00e9\\q\":\"\\n\\t\\r\\u0041\\\"z\",}");
    send_frame();
    end_test();
  endtask

  task automatic test_bare_and_empty_values();
    add_str("\r\n{\"a\":1 ,\"b\":,\"c\":}");
    send_frame();
    end_test();
  endtask

  task automatic test_syntax_errors();
    add_str("x");
    send_frame();
    add_str("{\"a\"");
    frame.push_back(8'h00);
    frame.push_back(8'hFF);
    send_frame();
    end_test();
  endtask

  task automatic test_early_end();
    add_str("{\"k\":\"v");
    send_frame();
    add_str("{\"k\":12");
    send_frame();
    end_test();
  endtask

  task automatic test_bytes_after_close();
    add_str("{ }junk");
    send_frame();
    end_test();
  endtask

  task automatic test_string_capacity();
    frame.push_back(CH_LBRACE);
    frame.push_back(CH_QUOTE);
    repeat (DEF_KEY_BYTES + 1) frame.push_back(plain_char());
    frame.push_back(CH_QUOTE);
    frame.push_back(CH_COLON);
    frame.push_back(CH_QUOTE);
    repeat (DEF_VALUE_BYTES + 1) frame.push_back(plain_char());
    frame.push_back(CH_QUOTE);
    frame.push_back(CH_RBRACE);
    send_frame();
    end_test();
  endtask

  task automatic test_too_many_entries();
    frame.push_back(CH_LBRACE);
    repeat (DEF_MAX_KEYS + 1) begin
      frame.push_back(CH_QUOTE);
      if ($urandom_range(0, 1) != 0) frame.push_back(token_char());
      frame.push_back(CH_QUOTE);
      frame.push_back(CH_COLON);
      if ($urandom_range(0, 1) != 0) frame.push_back(token_char());
      frame.push_back(CH_COMMA);
    end
    frame.push_back(CH_RBRACE);
    send_frame();
    end_test();
  endtask

  task automatic test_output_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_req  = 1'b1;
    gen_object(6);
    send_frame();
    end_test();
  endtask

  task automatic test_random_messages();
    int unsigned r;
    int unsigned n;
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        n = $urandom_range(1, 6);
        repeat (n) frame.push_back(rand_byte(0, 255));
      end else begin
        gen_object(($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 9));
        if (r < 20) begin
          frame[$urandom_range(0, frame.size() - 1)] = rand_byte(0, 255);
        end else if (r < 30) begin
          n = $urandom_range(1, frame.size() - 1);
          while (frame.size() > n) void'(frame.pop_back());
        end else if (r < 40) begin
          n = $urandom_range(1, 4);
          repeat (n) frame.push_back(rand_byte(0, 255));
        end
      end
      send_frame();
    end
    end_test();
  endtask

  initial begin
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'h00;
    msg_if.end_of_message = 1'b0;
    clear_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;

    test_escapes_and_trailing_comma();
    test_bare_and_empty_values();
    test_syntax_errors();
    test_early_end();
    test_bytes_after_close();
    directed_bytes = bytes_sent;

    test_string_capacity();
    test_too_many_entries();
    test_output_backpressure();
    test_random_messages();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_parse_out.size() != 0) begin
      $display("%0d expected results never arrived", expected_parse_out.size());
      mismatches += expected_parse_out.size();
    end
    $display("run covered %0d bytes in %0d messages: %0d character writes, %0d clean finishes,",
             bytes_sent, frames_sent, char_writes, runs_ok);
    $display("%0d error finishes, %0d long receiver holds; %0d mismatches",
             runs_failed, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
